// ----- rtl/stma_pkg.sv -----
// Package: shared types and constants for the sparse triplet merge-add block.
package stma_pkg;

    localparam int TERM_DEPTH_DEF = 1024;
    localparam int INDEX_BITS_DEF = 12;

    localparam int IDX_W   = 12;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 33;
    localparam int CNT_W   = 12;
    localparam int MODE_W  = 2;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 72;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_LOAD_A = 2'd1,
        MODE_LOAD_B = 2'd2,
        MODE_EMIT   = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } t_state;

endpackage

// ----- rtl/stma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sparse_triplet_merge_add.sv -----
// Top level: loads two coordinate term lists into RAMs and emits their merged sum.
//
//  channel | dir | handshake                | payload
//  s       | in  | i_s_tvalid / o_s_tready  | tuser=mode, tdata=row,col,value
//  m       | out | o_m_tvalid / i_m_tready  | tuser=empty, tlast=last, tdata=term,count,ovf
//
//  Clear and load beats finish in their accept cycle; an emit beat goes on into a
//  merge cycle: the accept cycle presents both list heads to the RAM read ports,
//  the merge cycle compares keys, adds and writes the output register.
//  The merge cycle holds while the output register is full and not taken.
//  Reset (synchronous, active low) empties both lists; no RAM sweep is needed.
module sparse_triplet_merge_add #(
    parameter int TERM_DEPTH = stma_pkg::TERM_DEPTH_DEF,
    parameter int INDEX_BITS = stma_pkg::INDEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [11:0] term_row, [23:12] term_col, [55:24] term_value
    input  logic [stma_pkg::S_DATA_W-1:0] i_s_tdata,
    // [1:0] mode
    input  logic [stma_pkg::MODE_W-1:0]   i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [11:0] out_row, [23:12] out_col, [56:24] out_value, [68:57] out_count,
    // [69] load_overflow, [71:70] zero
    output logic [stma_pkg::M_DATA_W-1:0] o_m_tdata,
    // [0] out_empty
    output logic                          o_m_tuser,
    output logic                          o_m_tlast
);

    localparam int AW = $clog2(TERM_DEPTH);
    localparam int CW = $clog2(TERM_DEPTH + 1);
    localparam int KW = 2 * INDEX_BITS;
    localparam int WW = KW + stma_pkg::VAL_W;
    localparam int IW = stma_pkg::IDX_W;
    localparam int VW = stma_pkg::VAL_W;
    localparam int SW = stma_pkg::SUM_W;
    localparam int NW = stma_pkg::CNT_W;

    function automatic logic [INDEX_BITS-1:0] f_to_idx(input logic [IW-1:0] x);
        logic [INDEX_BITS+IW-1:0] t;
        t = {{INDEX_BITS{1'b0}}, x};
        return t[INDEX_BITS-1:0];
    endfunction

    function automatic logic [IW-1:0] f_from_idx(input logic [INDEX_BITS-1:0] x);
        logic [INDEX_BITS+IW-1:0] t;
        t = {{IW{1'b0}}, x};
        return t[IW-1:0];
    endfunction

    stma_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_a_count, n_a_count, r_b_count, n_b_count;
    logic [CW-1:0]    r_a_next, n_a_next, r_b_next, n_b_next;
    logic [NW-1:0]    r_emitted, n_emitted;
    logic             r_ovf, n_ovf;
    logic             r_o_valid, n_o_valid;
    logic [IW-1:0]    r_o_row, n_o_row, r_o_col, n_o_col;
    logic [SW-1:0]    r_o_value, n_o_value;
    logic             r_o_empty, n_o_empty, r_o_last, n_o_last;
    logic [NW-1:0]    r_o_count, n_o_count;

    stma_pkg::t_mode  in_mode;
    logic [IW-1:0]    in_row, in_col;
    logic [VW-1:0]    in_value;
    logic             s_accept;
    logic             we_a, we_b;
    logic [WW-1:0]    wdata, rdata_a, rdata_b;
    logic [KW-1:0]    key_a, key_b;
    logic [VW-1:0]    val_a, val_b;
    logic             a_left, b_left, take_a, take_b;
    logic [SW-1:0]    add_a, add_b;

    assign in_mode  = stma_pkg::t_mode'(i_s_tuser);
    assign in_row   = i_s_tdata[11:0];
    assign in_col   = i_s_tdata[23:12];
    assign in_value = i_s_tdata[55:24];
    assign s_accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == stma_pkg::ST_IDLE);

    assign wdata = {in_value, f_to_idx(in_row), f_to_idx(in_col)};
    assign we_a  = s_accept && (in_mode == stma_pkg::MODE_LOAD_A) && (in_value != '0)
                   && (r_a_count < CW'(TERM_DEPTH));
    assign we_b  = s_accept && (in_mode == stma_pkg::MODE_LOAD_B) && (in_value != '0)
                   && (r_b_count < CW'(TERM_DEPTH));

    stma_ram #(.WIDTH(WW), .DEPTH(TERM_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_a_count[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_a_next[AW-1:0]),
        .o_rdata (rdata_a)
    );

    stma_ram #(.WIDTH(WW), .DEPTH(TERM_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_b_count[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_b_next[AW-1:0]),
        .o_rdata (rdata_b)
    );

    // key is {row, col}: row sits above col in the stored word
    assign key_a  = rdata_a[KW-1:0];
    assign key_b  = rdata_b[KW-1:0];
    assign val_a  = rdata_a[WW-1:KW];
    assign val_b  = rdata_b[WW-1:KW];
    assign a_left = r_a_next < r_a_count;
    assign b_left = r_b_next < r_b_count;
    assign take_a = a_left && (!b_left || key_a <= key_b);
    assign take_b = b_left && (!a_left || key_b <= key_a);
    assign add_a  = take_a ? {val_a[VW-1], val_a} : '0;
    assign add_b  = take_b ? {val_b[VW-1], val_b} : '0;

    always_comb begin
        n_state   = r_state;
        n_a_count = r_a_count;
        n_b_count = r_b_count;
        n_a_next  = r_a_next;
        n_b_next  = r_b_next;
        n_emitted = r_emitted;
        n_ovf     = r_ovf;
        n_o_valid = r_o_valid && !i_m_tready;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        n_o_value = r_o_value;
        n_o_empty = r_o_empty;
        n_o_last  = r_o_last;
        n_o_count = r_o_count;
        unique case (r_state)
            stma_pkg::ST_IDLE: begin
                if (s_accept) begin
                    unique case (in_mode)
                        stma_pkg::MODE_CLEAR: begin
                            n_a_count = '0;
                            n_b_count = '0;
                            n_a_next  = '0;
                            n_b_next  = '0;
                            n_emitted = '0;
                            n_ovf     = 1'b0;
                        end
                        stma_pkg::MODE_LOAD_A: begin
                            if (we_a) begin
                                n_a_count = r_a_count + CW'(1);
                            end else if (in_value != '0) begin
                                n_ovf = 1'b1;
                            end
                        end
                        stma_pkg::MODE_LOAD_B: begin
                            if (we_b) begin
                                n_b_count = r_b_count + CW'(1);
                            end else if (in_value != '0) begin
                                n_ovf = 1'b1;
                            end
                        end
                        stma_pkg::MODE_EMIT: begin
                            n_state = stma_pkg::ST_MERGE;
                        end
                    endcase
                end
            end
            stma_pkg::ST_MERGE: begin
                if (!r_o_valid || i_m_tready) begin
                    n_state   = stma_pkg::ST_IDLE;
                    n_o_valid = 1'b1;
                    if (take_a) begin
                        n_a_next = r_a_next + CW'(1);
                    end
                    if (take_b) begin
                        n_b_next = r_b_next + CW'(1);
                    end
                    if (take_a || take_b) begin
                        n_emitted = r_emitted + NW'(1);
                    end
                    n_o_empty = !take_a && !take_b;
                    n_o_value = add_a + add_b;
                    if (take_a) begin
                        n_o_row = f_from_idx(rdata_a[KW-1:INDEX_BITS]);
                        n_o_col = f_from_idx(rdata_a[INDEX_BITS-1:0]);
                    end else if (take_b) begin
                        n_o_row = f_from_idx(rdata_b[KW-1:INDEX_BITS]);
                        n_o_col = f_from_idx(rdata_b[INDEX_BITS-1:0]);
                    end else begin
                        n_o_row = '0;
                        n_o_col = '0;
                    end
                    n_o_last  = (take_a || take_b) && (n_a_next >= r_a_count)
                                && (n_b_next >= r_b_count);
                    n_o_count = n_emitted;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= stma_pkg::ST_IDLE;
            r_a_count <= '0;
            r_b_count <= '0;
            r_a_next  <= '0;
            r_b_next  <= '0;
            r_emitted <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_a_count <= n_a_count;
            r_b_count <= n_b_count;
            r_a_next  <= n_a_next;
            r_b_next  <= n_b_next;
            r_emitted <= n_emitted;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    // hold payload once loaded; the overflow flag travels with the beat
    logic r_o_ovf;

    always_ff @(posedge i_clk) begin
        r_o_row   <= n_o_row;
        r_o_col   <= n_o_col;
        r_o_value <= n_o_value;
        r_o_empty <= n_o_empty;
        r_o_last  <= n_o_last;
        r_o_count <= n_o_count;
        if (r_state == stma_pkg::ST_MERGE && (!r_o_valid || i_m_tready)) begin
            r_o_ovf <= r_ovf;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {2'b00, r_o_ovf, r_o_count, r_o_value, r_o_col, r_o_row};
    assign o_m_tuser  = r_o_empty;
    assign o_m_tlast  = r_o_last;

endmodule

// ----- rtl/stma_checker.sv -----
// Checker: port-level assertions for the merge-add block, bound to the top level.
module stma_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [stma_pkg::MODE_W-1:0]   i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [stma_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic                          o_m_tuser,
    input logic                          o_m_tlast
);

    logic s_emit;
    assign s_emit = i_s_tvalid && o_s_tready
                    && (i_s_tuser == stma_pkg::MODE_EMIT);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat dropped or changed while stalled");

    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> !o_m_tlast && (o_m_tdata[56:0] == '0))
        else $error("empty beat carries a term or last");

    a_beat_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(s_emit, 2))
        else $error("output beat without an emit two cycles earlier");

    a_busy_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_emit |=> !o_s_tready)
        else $error("input accepted during merge cycle");

endmodule

bind sparse_triplet_merge_add stma_checker u_stma_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ----- tb/sparse_triplet_merge_add_tb.sv -----
// Testbench for sparse_triplet_merge_add: directed table and random merge sets.
`timescale 1ns / 100ps

module sparse_triplet_merge_add_tb;

    localparam int RANDOM_ITEMS = 900;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [stma_pkg::IDX_W-1:0] row;
        logic [stma_pkg::IDX_W-1:0] col;
        logic [stma_pkg::VAL_W-1:0] value;
    } t_held_term;

    typedef struct packed {
        logic [stma_pkg::IDX_W-1:0] row;
        logic [stma_pkg::IDX_W-1:0] col;
        logic [stma_pkg::SUM_W-1:0] value;
        logic                       empty;
        logic                       last;
        logic [stma_pkg::CNT_W-1:0] count;
        logic                       ovf;
    } t_merged_term;

    typedef struct packed {
        stma_pkg::t_mode            mode;
        logic [stma_pkg::IDX_W-1:0] row;
        logic [stma_pkg::IDX_W-1:0] col;
        logic [stma_pkg::VAL_W-1:0] value;
        logic                       typed;
        t_merged_term               want;
    } t_stim_row;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [stma_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [stma_pkg::MODE_W-1:0]   s_tuser  = stma_pkg::MODE_CLEAR;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [stma_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    // merge predictor state
    t_held_term a_store [stma_pkg::TERM_DEPTH_DEF];
    t_held_term b_store [stma_pkg::TERM_DEPTH_DEF];
    int         a_len, b_len, a_pos, b_pos, emitted_cnt;
    logic       dropped_flag;

    t_merged_term pending_terms [$];

    int fail_count;
    int live_beats;
    int burst_left;
    bit steady;
    int terms_checked, empty_seen, zero_sums, last_seen, ovf_seen;
    int rx_cycle;

    t_stim_row directed_plan [24] = '{
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b1,
          '{12'h000, 12'h000, 33'h0_0000_0000, 1'b1, 1'b0, 12'd0, 1'b0}},
        '{stma_pkg::MODE_LOAD_A, 12'h000, 12'h000, 32'h8000_0000, 1'b0, '0},
        '{stma_pkg::MODE_LOAD_B, 12'h000, 12'h000, 32'h8000_0000, 1'b0, '0},
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b1,
          '{12'h000, 12'h000, 33'h1_0000_0000, 1'b0, 1'b1, 12'd1, 1'b0}},
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b1,
          '{12'h000, 12'h000, 33'h0_0000_0000, 1'b1, 1'b0, 12'd1, 1'b0}},
        '{stma_pkg::MODE_LOAD_A, 12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 1'b0, '0},
        '{stma_pkg::MODE_LOAD_B, 12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 1'b0, '0},
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b1,
          '{12'hFFF, 12'hFFF, 33'h0_FFFF_FFFE, 1'b0, 1'b1, 12'd2, 1'b0}},
        '{stma_pkg::MODE_CLEAR,  12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{stma_pkg::MODE_LOAD_A, 12'h001, 12'h002, 32'h0000_0000, 1'b0, '0},
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b1,
          '{12'h000, 12'h000, 33'h0_0000_0000, 1'b1, 1'b0, 12'd0, 1'b0}},
        '{stma_pkg::MODE_LOAD_A, 12'h005, 12'h005, 32'h0000_0005, 1'b0, '0},
        '{stma_pkg::MODE_LOAD_B, 12'h005, 12'h005, 32'hFFFF_FFFB, 1'b0, '0},
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b1,
          '{12'h005, 12'h005, 33'h0_0000_0000, 1'b0, 1'b1, 12'd1, 1'b0}},
        '{stma_pkg::MODE_LOAD_B, 12'hAAA, 12'h555, 32'h5555_5555, 1'b0, '0},
        '{stma_pkg::MODE_LOAD_A, 12'h555, 12'hAAA, 32'hAAAA_AAAA, 1'b0, '0},
        '{stma_pkg::MODE_LOAD_A, 12'h100, 12'h000, 32'h0000_0001, 1'b0, '0},
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b0, '0},
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b0, '0},
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b0, '0},
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b1,
          '{12'h000, 12'h000, 33'h0_0000_0000, 1'b1, 1'b0, 12'd4, 1'b0}},
        '{stma_pkg::MODE_CLEAR,  12'h000, 12'h000, 32'h0000_0000, 1'b0, '0},
        '{stma_pkg::MODE_LOAD_B, 12'h003, 12'h003, 32'hFFFF_FFFF, 1'b0, '0},
        '{stma_pkg::MODE_EMIT,   12'h000, 12'h000, 32'h0000_0000, 1'b1,
          '{12'h003, 12'h003, 33'h1_FFFF_FFFF, 1'b0, 1'b1, 12'd1, 1'b0}}
    };

    sparse_triplet_merge_add u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [stma_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    task automatic merge_step(input stma_pkg::t_mode mode,
                              input logic [stma_pkg::IDX_W-1:0] row,
                              input logic [stma_pkg::IDX_W-1:0] col,
                              input logic [stma_pkg::VAL_W-1:0] value,
                              output bit produced, output t_merged_term res);
        t_held_term ha, hb;
        bit         a_live, b_live, take_a, take_b;
        res      = '0;
        produced = 1'b0;
        ha       = '0;
        hb       = '0;
        case (mode)
            stma_pkg::MODE_CLEAR: begin
                a_len        = 0;
                b_len        = 0;
                a_pos        = 0;
                b_pos        = 0;
                emitted_cnt  = 0;
                dropped_flag = 1'b0;
            end
            stma_pkg::MODE_LOAD_A: begin
                if (value != '0) begin
                    if (a_len >= stma_pkg::TERM_DEPTH_DEF) begin
                        dropped_flag = 1'b1;
                    end else begin
                        a_store[a_len] = '{row, col, value};
                        a_len++;
                    end
                end
            end
            stma_pkg::MODE_LOAD_B: begin
                if (value != '0) begin
                    if (b_len >= stma_pkg::TERM_DEPTH_DEF) begin
                        dropped_flag = 1'b1;
                    end else begin
                        b_store[b_len] = '{row, col, value};
                        b_len++;
                    end
                end
            end
            default: begin
                produced = 1'b1;
                a_live   = a_pos < a_len;
                b_live   = b_pos < b_len;
                if (!a_live && !b_live) begin
                    res.empty = 1'b1;
                end else begin
                    if (a_live) ha = a_store[a_pos];
                    if (b_live) hb = b_store[b_pos];
                    take_a = a_live && (!b_live || {ha.row, ha.col} <= {hb.row, hb.col});
                    take_b = b_live && (!a_live || {hb.row, hb.col} <= {ha.row, ha.col});
                    res.row   = take_a ? ha.row : hb.row;
                    res.col   = take_a ? ha.col : hb.col;
                    res.value = (take_a ? {ha.value[stma_pkg::VAL_W-1], ha.value} : 33'd0)
                              + (take_b ? {hb.value[stma_pkg::VAL_W-1], hb.value} : 33'd0);
                    if (take_a) a_pos++;
                    if (take_b) b_pos++;
                    emitted_cnt++;
                    res.last = (a_pos >= a_len) && (b_pos >= b_len);
                end
                res.count = stma_pkg::CNT_W'(emitted_cnt);
                res.ovf   = dropped_flag;
            end
        endcase
    endtask

    task automatic send_beat(input stma_pkg::t_mode mode,
                             input logic [stma_pkg::IDX_W-1:0] row,
                             input logic [stma_pkg::IDX_W-1:0] col,
                             input logic [stma_pkg::VAL_W-1:0] value,
                             input logic typed = 1'b0, input t_merged_term want = '0);
        bit           produced;
        t_merged_term predicted;
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            if (!steady) repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {value, col, row};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        merge_step(mode, row, col, value, produced, predicted);
        if (produced) pending_terms.push_back(typed ? want : predicted);
        if (!((mode == stma_pkg::MODE_LOAD_A || mode == stma_pkg::MODE_LOAD_B)
              && value == '0)) live_beats++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (pending_terms.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(negedge clk) begin
        rx_cycle++;
        case (rx_cycle[10:8])
            3'd1: m_tready = rx_cycle[0];
            3'd2: m_tready = rx_cycle[3:0] != 4'd0;
            3'd3: m_tready = $urandom_range(0, 3) != 0;
            3'd4: m_tready = rx_cycle[4];
            3'd5: m_tready = $urandom_range(0, 1) != 0;
            default: m_tready = 1'b1;
        endcase
    end

    always @(posedge clk) begin : result_check
        t_merged_term seen, want;
        if (rst_n && m_tvalid && m_tready) begin
            seen = '{m_tdata[11:0], m_tdata[23:12], m_tdata[56:24], m_tuser, m_tlast,
                     m_tdata[68:57], m_tdata[69]};
            if (pending_terms.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %0h", $time, seen);
                fail_count++;
            end else begin
                want = pending_terms.pop_front();
                check_field("out_row", 64'(want.row), 64'(seen.row));
                check_field("out_col", 64'(want.col), 64'(seen.col));
                check_field("out_value", 64'(want.value), 64'(seen.value));
                check_field("out_empty", 64'(want.empty), 64'(seen.empty));
                check_field("out_last", 64'(want.last), 64'(seen.last));
                check_field("out_count", 64'(want.count), 64'(seen.count));
                check_field("load_overflow", 64'(want.ovf), 64'(seen.ovf));
                check_field("tdata pad", 64'd0, 64'(m_tdata[71:70]));
            end
            terms_checked++;
            if (seen.empty) empty_seen++;
            if (!seen.empty && seen.value == '0) zero_sums++;
            if (seen.last) last_seen++;
            if (seen.ovf) ovf_seen++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int              k, nkeys, step_max, sel, random_base;
        logic [23:0]     key;
        t_held_term      held;
        t_held_term      a_list [$];
        t_held_term      b_list [$];
        stma_pkg::t_mode noise_mode;
        logic [31:0]     noise_value;

        a_len        = 0;
        b_len        = 0;
        a_pos        = 0;
        b_pos        = 0;
        emitted_cnt  = 0;
        dropped_flag = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_plan[i]) begin
            send_beat(directed_plan[i].mode, directed_plan[i].row, directed_plan[i].col,
                      directed_plan[i].value, directed_plan[i].typed, directed_plan[i].want);
        end
        wait_drained();

        random_base = live_beats;
        while (live_beats - random_base < RANDOM_ITEMS) begin
            steady = $urandom_range(0, 4) == 0;
            if ($urandom_range(0, 9) == 0) wait_drained();
            if ($urandom_range(0, 6) != 0) begin
                send_beat(stma_pkg::MODE_CLEAR, 12'($urandom), 12'($urandom), $urandom);
                nkeys    = $urandom_range(0, 12);
                step_max = 1 << $urandom_range(0, 20);
                key      = 24'($urandom_range(0, (1 << 24) - 1 - nkeys * step_max));
                for (k = 0; k < nkeys; k++) begin
                    held = '{key[23:12], key[11:0], pick_value()};
                    sel  = $urandom_range(0, 2);
                    if (sel != 1) a_list.push_back(held);
                    if (sel != 0) begin
                        if (sel == 2 && $urandom_range(0, 3) == 0) held.value = -held.value;
                        else if (sel == 2) held.value = pick_value();
                        b_list.push_back(held);
                    end
                    key = key + 24'($urandom_range(1, step_max));
                end
                while (a_list.size() + b_list.size() != 0) begin
                    if (b_list.size() == 0
                        || (a_list.size() != 0 && $urandom_range(0, 1) != 0)) begin
                        held = a_list.pop_front();
                        send_beat(stma_pkg::MODE_LOAD_A, held.row, held.col, held.value);
                    end else begin
                        held = b_list.pop_front();
                        send_beat(stma_pkg::MODE_LOAD_B, held.row, held.col, held.value);
                    end
                end
                repeat (nkeys + $urandom_range(0, 2)) begin
                    send_beat(stma_pkg::MODE_EMIT, 12'($urandom), 12'($urandom), $urandom);
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    noise_mode = stma_pkg::t_mode'(2'($urandom_range(0, 3)));
                    if (noise_mode == stma_pkg::MODE_CLEAR && $urandom_range(0, 1) == 0)
                        noise_mode = stma_pkg::MODE_EMIT;
                    noise_value = ($urandom_range(0, 5) == 0) ? 32'd0 : pick_value();
                    send_beat(noise_mode, 12'($urandom), 12'($urandom), noise_value);
                end
            end
        end

        s_tvalid = 1'b0;
        while (pending_terms.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d input beats, %0d merged terms checked (%0d empty, %0d zero sums).",
                 live_beats, terms_checked, empty_seen, zero_sums);
        $display("Run: %0d merges ran to their final term, %0d results carried the drop flag.",
                 last_seen, ovf_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
